// ----- rtl/dna_pkg.sv -----
// ----------------------------------------------------------------------------
// dna_pkg: shared constants, types and helpers for the dual number ALU
// Operation and status codes, the stage record types and saturation helpers.
// ----------------------------------------------------------------------------
package dna_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    // quotient bits formed by each long divider, enough to see saturation
    localparam int QUOT_BITS     = 34;

    // operation codes
    localparam logic [2:0] FN_ADD  = 3'd0;
    localparam logic [2:0] FN_SUB  = 3'd1;
    localparam logic [2:0] FN_MUL  = 3'd2;
    localparam logic [2:0] FN_DIV  = 3'd3;
    localparam logic [2:0] FN_SQRT = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAT   = 2'd1;
    localparam logic [1:0] ST_DIVZ  = 2'd2;
    localparam logic [1:0] ST_NEGSQ = 2'd3;

    localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    localparam logic signed [65:0] WIDE_MAX = 66'sd2147483647;
    localparam logic signed [65:0] WIDE_MIN = -66'sd2147483648;

    // saturated value with its overflow flag
    typedef struct packed {
        logic [31:0] val;
        logic        ovf;
    } t_sat;

    // item record after the front end
    typedef struct packed {
        logic [2:0]  func;
        logic [1:0]  st;
        logic [31:0] rr;
        logic [31:0] rd;
        logic        ovf;
        logic [63:0] mag2;
        logic        neg2;
        logic [63:0] den2;
        logic [31:0] ar;
        logic [31:0] ad;
        logic [31:0] br;
    } t_mid;

    // item record carried through the dividers
    typedef struct packed {
        logic [2:0]  func;
        logic [1:0]  st;
        logic [31:0] rr;
        logic [31:0] rd;
        logic        ovf;
        logic [31:0] root;
        logic        ovf1;
        logic        ovf2;
        logic        neg1;
        logic        neg2;
    } t_side;

    // clamp a wide signed value to 32 bits
    function automatic t_sat sat_wide(input logic signed [65:0] v);
        t_sat s;
        s.val = v[31:0];
        s.ovf = 1'b0;
        if (v > WIDE_MAX) begin
            s.val = Q_MAX;
            s.ovf = 1'b1;
        end else if (v < WIDE_MIN) begin
            s.val = Q_MIN;
            s.ovf = 1'b1;
        end
        return s;
    endfunction

    // apply a sign to a quotient magnitude and clamp
    function automatic t_sat sat_mag(input logic [33:0] q, input logic big, input logic neg);
        t_sat s;
        s.val = q[31:0];
        s.ovf = 1'b0;
        if (big) begin
            s.val = neg ? Q_MIN : Q_MAX;
            s.ovf = 1'b1;
        end else if (!neg) begin
            if (q > 34'h0_7fff_ffff) begin
                s.val = Q_MAX;
                s.ovf = 1'b1;
            end
        end else begin
            if (q > 34'h0_8000_0000) begin
                s.val = Q_MIN;
                s.ovf = 1'b1;
            end else begin
                s.val = (~q[31:0]) + 32'd1;
            end
        end
        return s;
    endfunction

    // magnitude of a signed 32 bit value
    function automatic logic [31:0] abs32(input logic [31:0] x);
        return x[31] ? ((~x) + 32'd1) : x;
    endfunction

endpackage

// ----- rtl/dna_front.sv -----
// ----------------------------------------------------------------------------
// dna_front: input register, products and simple results
// Three stages: input capture, four 32x32 products with add and subtract,
// then the multiply results and the derivative numerator of the divide.
// ----------------------------------------------------------------------------
module dna_front #(
    parameter int FRAC_BITS = dna_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [2:0]         i_func,
    input  logic [31:0]        i_ar,
    input  logic [31:0]        i_ad,
    input  logic [31:0]        i_br,
    input  logic [31:0]        i_bd,
    output logic               o_vld,
    output dna_pkg::t_mid      o_mid
);

    logic               r0_vld;
    logic [2:0]         r0_func;
    logic signed [31:0] r0_ar, r0_ad, r0_br, r0_bd;

    logic               r1_vld;
    logic [2:0]         r1_func;
    logic [1:0]         r1_st;
    logic [31:0]        r1_ar, r1_ad, r1_br;
    logic signed [63:0] r1_prr, r1_p1, r1_p2, r1_pbb;
    dna_pkg::t_sat      r1_sr, r1_sd;

    logic               r2_vld;
    dna_pkg::t_mid      r2_mid;

    logic signed [32:0] n_sum_r, n_sum_d;
    logic [1:0]         n_st;
    logic signed [63:0] prr_sh;
    logic signed [64:0] sum65, sum_sh, diff65, magd;
    dna_pkg::t_sat      mul_r, mul_d;
    dna_pkg::t_mid      n_mid;

    // input capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_vld;
        end
        if (i_en) begin
            r0_func <= i_func;
            r0_ar   <= i_ar;
            r0_ad   <= i_ad;
            r0_br   <= i_br;
            r0_bd   <= i_bd;
        end
    end

    // add or subtract, early status codes
    always_comb begin
        if (r0_func == dna_pkg::FN_SUB) begin
            n_sum_r = $signed({r0_ar[31], r0_ar}) - $signed({r0_br[31], r0_br});
            n_sum_d = $signed({r0_ad[31], r0_ad}) - $signed({r0_bd[31], r0_bd});
        end else begin
            n_sum_r = $signed({r0_ar[31], r0_ar}) + $signed({r0_br[31], r0_br});
            n_sum_d = $signed({r0_ad[31], r0_ad}) + $signed({r0_bd[31], r0_bd});
        end
        n_st = dna_pkg::ST_OK;
        if (r0_func == dna_pkg::FN_DIV && r0_br == 32'sd0) begin
            n_st = dna_pkg::ST_DIVZ;
        end else if (r0_func == dna_pkg::FN_SQRT && r0_ar[31]) begin
            n_st = dna_pkg::ST_NEGSQ;
        end else if (r0_func == dna_pkg::FN_SQRT && r0_ar == 32'sd0) begin
            n_st = dna_pkg::ST_DIVZ;
        end
    end

    // products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= r0_vld;
        end
        if (i_en) begin
            r1_func <= r0_func;
            r1_st   <= n_st;
            r1_ar   <= r0_ar;
            r1_ad   <= r0_ad;
            r1_br   <= r0_br;
            r1_prr  <= r0_ar * r0_br;
            r1_p1   <= r0_ar * r0_bd;
            r1_p2   <= r0_ad * r0_br;
            r1_pbb  <= r0_br * r0_br;
            r1_sr   <= dna_pkg::sat_wide($signed({{33{n_sum_r[32]}}, n_sum_r}));
            r1_sd   <= dna_pkg::sat_wide($signed({{33{n_sum_d[32]}}, n_sum_d}));
        end
    end

    // multiply results and divide numerator
    always_comb begin
        prr_sh = r1_prr >>> FRAC_BITS;
        mul_r  = dna_pkg::sat_wide($signed({{2{prr_sh[63]}}, prr_sh}));
        sum65  = $signed({r1_p1[63], r1_p1}) + $signed({r1_p2[63], r1_p2});
        sum_sh = sum65 >>> FRAC_BITS;
        mul_d  = dna_pkg::sat_wide($signed({sum_sh[64], sum_sh}));
        diff65 = $signed({r1_p2[63], r1_p2}) - $signed({r1_p1[63], r1_p1});
        magd   = diff65[64] ? -diff65 : diff65;

        n_mid      = '0;
        n_mid.func = r1_func;
        n_mid.st   = r1_st;
        n_mid.mag2 = magd[63:0];
        n_mid.neg2 = diff65[64];
        n_mid.den2 = r1_pbb;
        n_mid.ar   = r1_ar;
        n_mid.ad   = r1_ad;
        n_mid.br   = r1_br;
        if (r1_func == dna_pkg::FN_ADD || r1_func == dna_pkg::FN_SUB) begin
            n_mid.rr  = r1_sr.val;
            n_mid.rd  = r1_sd.val;
            n_mid.ovf = r1_sr.ovf | r1_sd.ovf;
        end else if (r1_func == dna_pkg::FN_MUL) begin
            n_mid.rr  = mul_r.val;
            n_mid.rd  = mul_d.val;
            n_mid.ovf = mul_r.ovf | mul_d.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
        if (i_en) begin
            r2_mid <= n_mid;
        end
    end

    assign o_vld = r2_vld;
    assign o_mid = r2_mid;

endmodule

// ----- rtl/dna_sqrt.sv -----
// ----------------------------------------------------------------------------
// dna_sqrt: pipelined integer square root
// One root bit per stage of floor(sqrt(a_real * 2^FRAC_BITS)); the item
// record travels alongside.
// ----------------------------------------------------------------------------
module dna_sqrt #(
    parameter int FRAC_BITS = dna_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  dna_pkg::t_mid      i_mid,
    output logic               o_vld,
    output dna_pkg::t_mid      o_mid,
    output logic [31:0]        o_root
);

    localparam int NW = 31 + FRAC_BITS;
    localparam int RW = (NW + 1) / 2;
    localparam int NP = 2 * RW;

    logic [RW-1:0]   r_vld;
    dna_pkg::t_mid   r_mid  [RW];
    logic [RW+1:0]   r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [NP-1:0]   r_n    [RW];

    logic            s_vld  [RW+1];
    dna_pkg::t_mid   s_mid  [RW+1];
    logic [RW+1:0]   s_rem  [RW+1];
    logic [RW-1:0]   s_root [RW+1];
    logic [NP-1:0]   s_n    [RW+1];

    // stage inputs
    assign s_vld[0]  = i_vld;
    assign s_mid[0]  = i_mid;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_n[0]    = NP'({i_mid.ar[30:0], {FRAC_BITS{1'b0}}});

    for (genvar i = 0; i < RW; i++) begin : g_stage
        logic [RW+1:0] remsh, trial, n_rem;
        logic          ge;

        // one root bit
        always_comb begin
            remsh = {s_rem[i][RW-1:0], s_n[i][NP-1 -: 2]};
            trial = {s_root[i], 2'b01};
            ge    = (remsh >= trial);
            n_rem = ge ? (remsh - trial) : remsh;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= s_vld[i];
            end
            if (i_en) begin
                r_mid[i]  <= s_mid[i];
                r_rem[i]  <= n_rem;
                r_root[i] <= {s_root[i][RW-2:0], ge};
                r_n[i]    <= s_n[i] << 2;
            end
        end

        assign s_vld[i+1]  = r_vld[i];
        assign s_mid[i+1]  = r_mid[i];
        assign s_rem[i+1]  = r_rem[i];
        assign s_root[i+1] = r_root[i];
        assign s_n[i+1]    = r_n[i];
    end

    assign o_vld  = s_vld[RW];
    assign o_mid  = s_mid[RW];
    assign o_root = 32'(s_root[RW]);

endmodule

// ----- rtl/dna_div.sv -----
// ----------------------------------------------------------------------------
// dna_div: two pipelined long dividers and the result stage
// Divider one forms the real quotient (or the sqrt derivative), divider two
// the derivative quotient of the divide; the last stage selects and clamps.
// ----------------------------------------------------------------------------
module dna_div #(
    parameter int FRAC_BITS = dna_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  dna_pkg::t_mid      i_mid,
    input  logic [31:0]        i_root,
    output logic               o_vld,
    output logic [31:0]        o_rr,
    output logic [31:0]        o_rd,
    output logic [1:0]         o_st
);

    localparam int QB = dna_pkg::QUOT_BITS;

    logic [QB:0]      r_vld;
    dna_pkg::t_side   r_side [QB+1];
    logic [31:0]      r_r1   [QB+1];
    logic [31:0]      r_d1   [QB+1];
    logic [QB-1:0]    r_l1   [QB+1];
    logic [QB-1:0]    r_q1   [QB+1];
    logic [63:0]      r_r2   [QB+1];
    logic [63:0]      r_d2   [QB+1];
    logic [QB-1:0]    r_l2   [QB+1];
    logic [QB-1:0]    r_q2   [QB+1];

    logic                  is_sqrt;
    logic [31:0]           x_mag, d1;
    logic [32+FRAC_BITS-1:0] n1_full;
    logic [64+FRAC_BITS-1:0] n2_full;
    logic [31:0]           r1_init;
    logic [63:0]           r2_init;
    dna_pkg::t_side        n_side;

    logic                  r_f_vld;
    logic [31:0]           r_f_rr, r_f_rd;
    logic [1:0]            r_f_st;
    dna_pkg::t_sat         q1_res, q2_res;
    logic [31:0]           n_rr, n_rd;
    logic                  n_ovf;
    logic [1:0]            n_st;

    // divider operand set-up
    always_comb begin
        is_sqrt = (i_mid.func == dna_pkg::FN_SQRT);
        x_mag   = dna_pkg::abs32(is_sqrt ? i_mid.ad : i_mid.ar);
        d1      = is_sqrt ? {i_root[30:0], 1'b0} : dna_pkg::abs32(i_mid.br);
        n1_full = {x_mag, {FRAC_BITS{1'b0}}};
        n2_full = {i_mid.mag2, {FRAC_BITS{1'b0}}};
        r1_init = 32'(n1_full >> QB);
        r2_init = 64'(n2_full >> QB);

        n_side      = '0;
        n_side.func = i_mid.func;
        n_side.st   = i_mid.st;
        n_side.rr   = i_mid.rr;
        n_side.rd   = i_mid.rd;
        n_side.ovf  = i_mid.ovf;
        n_side.root = i_root;
        n_side.ovf1 = (r1_init >= d1);
        n_side.ovf2 = (r2_init >= i_mid.den2);
        n_side.neg1 = is_sqrt ? i_mid.ad[31] : (i_mid.ar[31] ^ i_mid.br[31]);
        n_side.neg2 = i_mid.neg2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
        if (i_en) begin
            r_side[0] <= n_side;
            r_r1[0]   <= r1_init;
            r_d1[0]   <= d1;
            r_l1[0]   <= n1_full[QB-1:0];
            r_q1[0]   <= '0;
            r_r2[0]   <= r2_init;
            r_d2[0]   <= i_mid.den2;
            r_l2[0]   <= n2_full[QB-1:0];
            r_q2[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_stage
        logic [32:0] t1, n_r1w;
        logic [64:0] t2, n_r2w;
        logic        ge1, ge2;

        // one quotient bit in each divider
        always_comb begin
            t1    = {r_r1[k-1], r_l1[k-1][QB-1]};
            ge1   = (t1 >= {1'b0, r_d1[k-1]});
            n_r1w = ge1 ? (t1 - {1'b0, r_d1[k-1]}) : t1;
            t2    = {r_r2[k-1], r_l2[k-1][QB-1]};
            ge2   = (t2 >= {1'b0, r_d2[k-1]});
            n_r2w = ge2 ? (t2 - {1'b0, r_d2[k-1]}) : t2;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
            if (i_en) begin
                r_side[k] <= r_side[k-1];
                r_r1[k]   <= n_r1w[31:0];
                r_d1[k]   <= r_d1[k-1];
                r_l1[k]   <= r_l1[k-1] << 1;
                r_q1[k]   <= {r_q1[k-1][QB-2:0], ge1};
                r_r2[k]   <= n_r2w[63:0];
                r_d2[k]   <= r_d2[k-1];
                r_l2[k]   <= r_l2[k-1] << 1;
                r_q2[k]   <= {r_q2[k-1][QB-2:0], ge2};
            end
        end
    end

    // result selection and status
    always_comb begin
        q1_res = dna_pkg::sat_mag(r_q1[QB], r_side[QB].ovf1, r_side[QB].neg1);
        q2_res = dna_pkg::sat_mag(r_q2[QB], r_side[QB].ovf2, r_side[QB].neg2);
        n_rr   = '0;
        n_rd   = '0;
        n_ovf  = 1'b0;
        unique case (r_side[QB].func)
            dna_pkg::FN_ADD, dna_pkg::FN_SUB, dna_pkg::FN_MUL: begin
                n_rr  = r_side[QB].rr;
                n_rd  = r_side[QB].rd;
                n_ovf = r_side[QB].ovf;
            end
            dna_pkg::FN_DIV: begin
                if (r_side[QB].st == dna_pkg::ST_OK) begin
                    n_rr  = q1_res.val;
                    n_rd  = q2_res.val;
                    n_ovf = q1_res.ovf | q2_res.ovf;
                end
            end
            dna_pkg::FN_SQRT: begin
                if (r_side[QB].st == dna_pkg::ST_OK) begin
                    n_rr  = r_side[QB].root;
                    n_rd  = q1_res.val;
                    n_ovf = q1_res.ovf;
                end
            end
            default: begin
            end
        endcase
        if (r_side[QB].st != dna_pkg::ST_OK) begin
            n_st = r_side[QB].st;
        end else begin
            n_st = n_ovf ? dna_pkg::ST_SAT : dna_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (i_en) begin
            r_f_vld <= r_vld[QB];
        end
        if (i_en) begin
            r_f_rr <= n_rr;
            r_f_rd <= n_rd;
            r_f_st <= n_st;
        end
    end

    assign o_vld = r_f_vld;
    assign o_rr  = r_f_rr;
    assign o_rd  = r_f_rd;
    assign o_st  = r_f_st;

endmodule

// ----- rtl/dual_number_alu.sv -----
// ----------------------------------------------------------------------------
// dual_number_alu: forward-mode dual number ALU in signed fixed point
// Add, subtract, multiply, divide and square root on (real, derivative) pairs.
// ----------------------------------------------------------------------------
// Usage
//   Input stream: tuser carries the operation, tdata the two operands.
//   Output stream: tdata carries the result pair, tuser the status code.
//   Every item runs the same fixed pipeline, so results leave in order.
//   An item passes the front end, then RW = (32 + FRAC_BITS) / 2 square root
//   stages, then the dividers and the result stage.
//   The 34 stage long dividers follow the square root, one bit per stage.
//   Throughput: one item per cycle while the output item is taken or absent.
//   Stall: when the output item is not taken the whole pipeline holds and
//   o_s_tready falls in the same cycle; nothing is lost or repeated.
//   Reset: synchronous active-low reset clears every stage valid bit; the
//   pipeline is empty and ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module dual_number_alu #(
    parameter int FRAC_BITS = dna_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // a_real, a_dual, b_real, b_dual from the lowest bit up
    input  logic [127:0] i_s_tdata,
    // func
    input  logic [2:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // res_real, res_dual from the lowest bit up
    output logic [63:0]  o_m_tdata,
    // status
    output logic [1:0]   o_m_tuser
);

    logic          en;
    logic          front_vld, sqrt_vld;
    dna_pkg::t_mid front_mid, sqrt_mid;
    logic [31:0]   sqrt_root;
    logic [31:0]   res_rr, res_rd;

    // global pipeline advance
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    dna_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_tvalid),
        .i_func  (i_s_tuser),
        .i_ar    (i_s_tdata[31:0]),
        .i_ad    (i_s_tdata[63:32]),
        .i_br    (i_s_tdata[95:64]),
        .i_bd    (i_s_tdata[127:96]),
        .o_vld   (front_vld),
        .o_mid   (front_mid)
    );

    dna_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (front_vld),
        .i_mid   (front_mid),
        .o_vld   (sqrt_vld),
        .o_mid   (sqrt_mid),
        .o_root  (sqrt_root)
    );

    dna_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sqrt_vld),
        .i_mid   (sqrt_mid),
        .i_root  (sqrt_root),
        .o_vld   (o_m_tvalid),
        .o_rr    (res_rr),
        .o_rd    (res_rd),
        .o_st    (o_m_tuser)
    );

    assign o_m_tdata = {res_rd, res_rr};

endmodule

// ----- rtl/dna_check.sv -----
// ----------------------------------------------------------------------------
// dna_check: port-level assertions for the dual number ALU
// Watches the handshakes and the status against the result values.
// ----------------------------------------------------------------------------
module dna_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    // input side ready follows the output side
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("ready does not follow output stall");

    // a stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("stalled item changed");

    // error codes give zero results
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == dna_pkg::ST_DIVZ || o_m_tuser == dna_pkg::ST_NEGSQ)
            |-> o_m_tdata == 64'd0)
        else $error("error status with nonzero result");

    // saturation shows a clamped part
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == dna_pkg::ST_SAT
            |-> o_m_tdata[31:0] == dna_pkg::Q_MAX || o_m_tdata[31:0] == dna_pkg::Q_MIN
             || o_m_tdata[63:32] == dna_pkg::Q_MAX || o_m_tdata[63:32] == dna_pkg::Q_MIN)
        else $error("saturation status without clamped part");

    // pipeline empty after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind dual_number_alu dna_check u_dna_check (.*);
